### rtl/html_entity_decoder_assert.svh
// Assertion macros for the character reference decoder.
// No dependencies; included by hed_back, the module that checks itself.
`ifndef HTML_ENTITY_DECODER_ASSERT_SVH
`define HTML_ENTITY_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HED_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hed assertion failed");
`define HED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hed assertion failed");
`else
`define HED_ASSERT(lbl, clk, rstn, prop)
`define HED_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/hed_pkg.sv
// Shared types, constants and the name table of the reference decoder.
// No dependencies.
package hed_pkg;

    localparam int REF_WINDOW = 32;
    localparam int NAME_MAX   = 6;
    localparam int NAME_COUNT = 66;
    localparam int CW         = $clog2(REF_WINDOW + 1);
    localparam int LINE_DEPTH = 2 ** $clog2(REF_WINDOW + 2);
    localparam int PW         = $clog2(LINE_DEPTH);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [2:0]  len;
        logic [47:0] txt;
        logic [7:0]  code;
    } t_name_ent;

    localparam t_name_ent NAME_ROM [NAME_COUNT] = '{
        '{3'd2, 48'("lt"), 8'd60},      '{3'd2, 48'("gt"), 8'd62},
        '{3'd3, 48'("amp"), 8'd38},     '{3'd3, 48'("ETH"), 8'd208},
        '{3'd3, 48'("eth"), 8'd240},
        '{3'd4, 48'("quot"), 8'd34},    '{3'd4, 48'("Auml"), 8'd196},
        '{3'd4, 48'("Euml"), 8'd203},   '{3'd4, 48'("Iuml"), 8'd207},
        '{3'd4, 48'("Ouml"), 8'd214},   '{3'd4, 48'("Uuml"), 8'd220},
        '{3'd4, 48'("auml"), 8'd228},   '{3'd4, 48'("euml"), 8'd235},
        '{3'd4, 48'("iuml"), 8'd239},   '{3'd4, 48'("ouml"), 8'd246},
        '{3'd4, 48'("uuml"), 8'd252},   '{3'd4, 48'("yuml"), 8'd255},
        '{3'd5, 48'("Acirc"), 8'd194},  '{3'd5, 48'("Aring"), 8'd197},
        '{3'd5, 48'("AElig"), 8'd198},  '{3'd5, 48'("Ecirc"), 8'd202},
        '{3'd5, 48'("Icirc"), 8'd206},  '{3'd5, 48'("Ocirc"), 8'd212},
        '{3'd5, 48'("Ucirc"), 8'd219},  '{3'd5, 48'("THORN"), 8'd222},
        '{3'd5, 48'("szlig"), 8'd223},  '{3'd5, 48'("acirc"), 8'd226},
        '{3'd5, 48'("aring"), 8'd229},  '{3'd5, 48'("aelig"), 8'd230},
        '{3'd5, 48'("ecirc"), 8'd234},  '{3'd5, 48'("icirc"), 8'd238},
        '{3'd5, 48'("ocirc"), 8'd244},  '{3'd5, 48'("ucirc"), 8'd251},
        '{3'd5, 48'("thorn"), 8'd254},
        '{3'd6, 48'("Agrave"), 8'd192}, '{3'd6, 48'("Aacute"), 8'd193},
        '{3'd6, 48'("Atilde"), 8'd195}, '{3'd6, 48'("Ccedil"), 8'd199},
        '{3'd6, 48'("Egrave"), 8'd200}, '{3'd6, 48'("Eacute"), 8'd201},
        '{3'd6, 48'("Igrave"), 8'd204}, '{3'd6, 48'("Iacute"), 8'd205},
        '{3'd6, 48'("Ntilde"), 8'd209}, '{3'd6, 48'("Ograve"), 8'd210},
        '{3'd6, 48'("Oacute"), 8'd211}, '{3'd6, 48'("Otilde"), 8'd213},
        '{3'd6, 48'("Oslash"), 8'd216}, '{3'd6, 48'("Ugrave"), 8'd217},
        '{3'd6, 48'("Uacute"), 8'd218}, '{3'd6, 48'("Yacute"), 8'd221},
        '{3'd6, 48'("agrave"), 8'd224}, '{3'd6, 48'("aacute"), 8'd225},
        '{3'd6, 48'("atilde"), 8'd227}, '{3'd6, 48'("ccedil"), 8'd231},
        '{3'd6, 48'("egrave"), 8'd232}, '{3'd6, 48'("eacute"), 8'd233},
        '{3'd6, 48'("igrave"), 8'd236}, '{3'd6, 48'("iacute"), 8'd237},
        '{3'd6, 48'("ntilde"), 8'd241}, '{3'd6, 48'("ograve"), 8'd242},
        '{3'd6, 48'("oacute"), 8'd243}, '{3'd6, 48'("otilde"), 8'd245},
        '{3'd6, 48'("oslash"), 8'd248}, '{3'd6, 48'("ugrave"), 8'd249},
        '{3'd6, 48'("uacute"), 8'd250}, '{3'd6, 48'("yacute"), 8'd253}
    };

    // {hit, code}; key holds the name right aligned, zero padded
    function automatic logic [8:0] name_lookup(input logic [CW-1:0] cnt,
                                               input logic [47:0] key);
        logic [8:0] res;
        res = '0;
        for (int k = 0; k < NAME_COUNT; k++) begin
            if (CW'(NAME_ROM[k].len) == cnt && NAME_ROM[k].txt == key) begin
                res = {1'b1, NAME_ROM[k].code};
            end
        end
        return res;
    endfunction

endpackage

### rtl/hed_ifs.sv
// Handshake channels of the reference decoder: input words and result words.
// Depends on nothing.
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_end;
    modport source (output valid, in_byte, in_end, input ready);
    modport sink   (input valid, in_byte, in_end, output ready);
endinterface

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_done;
    modport source (output valid, out_byte, has_byte, run_last, string_done, input ready);
    modport sink   (input valid, out_byte, has_byte, run_last, string_done, output ready);
endinterface

### rtl/hed_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module hed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/hed_front.sv
// Input side: takes words off the input channel into a two entry queue.
// Depends on hed_pkg and hed_in_if.
module hed_front import hed_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hed_in_if.sink    i_in,
    output logic      o_valid,
    output t_item     o_item,
    input  logic      i_pop
);
    t_item      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{data: i_in.in_byte, last: i_in.in_end};
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

### rtl/hed_back.sv
// Back end: scans bytes from a line buffer, decodes references, replays
// failed ones, and drives the result channel. Depends on hed_pkg, hed_ifs, hed_ram.
`include "html_entity_decoder_assert.svh"
module hed_back import hed_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_item     i_item,
    output logic      o_pop,
    hed_out_if.source o_out
);
    typedef enum logic [1:0] {S_IDLE, S_RD, S_EXEC} t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp, r_sp, n_sp;
    logic          r_end, n_end;
    logic          r_in_ref, n_in_ref;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [8:0]    r_num, n_num;
    logic          r_nd, n_nd;
    logic          r_hash, n_hash;
    logic [47:0]   r_key, n_key;
    logic          r_pend_v, n_pend_v;
    logic [7:0]    r_pend_b, n_pend_b;
    logic          r_out_v, n_out_v;
    logic [7:0]    r_out_b, n_out_b;
    logic          r_out_has, n_out_has, r_out_last, n_out_last, r_out_done, n_out_done;

    logic          ram_we, ram_re;
    logic [7:0]    rd_b;
    logic          can_push;
    logic          is_digit, numeric, numeric2;
    logic [12:0]   num_mul;
    logic [8:0]    num_sat;
    logic [8:0]    lookup;
    logic          f_emit, f_fail, f_close, f_open, f_store;
    logic [7:0]    f_byte;

    function automatic logic num_allowed(input logic [8:0] v);
        return (v > 9'd8) && !(v >= 9'd11 && v <= 9'd31) &&
               !(v >= 9'd127 && v <= 9'd160) && (v < 9'd256);
    endfunction

    hed_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_item.data),
        .i_re    (ram_re),
        .i_raddr (r_rp),
        .o_rdata (rd_b)
    );

    assign can_push = !r_out_v || o_out.ready;
    assign is_digit = (rd_b >= CH_0) && (rd_b <= CH_9);
    assign numeric  = (r_cnt != '0) && r_hash;
    assign numeric2 = numeric || (r_cnt == '0 && rd_b == CH_HASH);
    assign num_mul  = {4'b0, r_num} * 13'd10 + 13'(rd_b[3:0]);
    assign num_sat  = (num_mul > 13'd256) ? 9'd256 : num_mul[8:0];
    assign lookup   = name_lookup(r_cnt, r_key);

    // one scan step on the byte just read from the line
    always_comb begin
        f_emit  = 1'b0;
        f_byte  = rd_b;
        f_fail  = 1'b0;
        f_close = 1'b0;
        f_open  = 1'b0;
        f_store = 1'b0;
        if (!r_in_ref) begin
            if (rd_b == CH_AMP) f_open = 1'b1;
            else f_emit = 1'b1;
        end else if (rd_b == CH_SEMI) begin
            if (numeric) begin
                f_emit  = !r_nd && num_allowed(r_num);
                f_byte  = r_num[7:0];
                f_close = 1'b1;
            end else if (lookup[8]) begin
                f_emit  = 1'b1;
                f_byte  = lookup[7:0];
                f_close = 1'b1;
            end else begin
                f_fail = 1'b1;
            end
        end else if (r_cnt >= CW'(REF_WINDOW) || (!numeric2 && r_cnt >= CW'(NAME_MAX))) begin
            f_fail = 1'b1;
        end else begin
            f_store = 1'b1;
        end
        if (f_fail) begin
            f_emit = 1'b1;
            f_byte = CH_AMP;
        end
    end

    always_comb begin
        n_state = r_state;  n_wp = r_wp;  n_rp = r_rp;  n_sp = r_sp;
        n_end = r_end;  n_in_ref = r_in_ref;  n_cnt = r_cnt;  n_num = r_num;
        n_nd = r_nd;  n_hash = r_hash;  n_key = r_key;
        n_pend_v = r_pend_v;  n_pend_b = r_pend_b;
        n_out_v = r_out_v && !o_out.ready;
        n_out_b = r_out_b;  n_out_has = r_out_has;
        n_out_last = r_out_last;  n_out_done = r_out_done;
        ram_we = 1'b0;  ram_re = 1'b0;  o_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    ram_we  = 1'b1;
                    o_pop   = 1'b1;
                    n_wp    = r_wp + 1'b1;
                    n_end   = i_item.last;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_rp != r_wp) begin
                    ram_re  = 1'b1;
                    n_rp    = r_rp + 1'b1;
                    n_state = S_EXEC;
                end else if (r_end && r_in_ref) begin
                    // string ends inside a reference: ampersand, then rescan
                    if (!r_pend_v || can_push) begin
                        if (r_pend_v) begin
                            n_out_v = 1'b1;  n_out_b = r_pend_b;  n_out_has = 1'b1;
                            n_out_last = 1'b0;  n_out_done = 1'b0;
                        end
                        n_pend_v = 1'b1;  n_pend_b = CH_AMP;
                        n_rp = r_sp;  n_in_ref = 1'b0;  n_cnt = '0;
                        n_num = '0;  n_nd = 1'b0;
                    end
                end else if (r_pend_v || r_end) begin
                    if (can_push) begin
                        n_out_v = 1'b1;  n_out_b = r_pend_v ? r_pend_b : 8'd0;
                        n_out_has = r_pend_v;  n_out_last = 1'b1;  n_out_done = r_end;
                        n_pend_v = 1'b0;  n_end = 1'b0;  n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                if (!(f_emit && r_pend_v && !can_push)) begin
                    if (f_emit) begin
                        if (r_pend_v) begin
                            n_out_v = 1'b1;  n_out_b = r_pend_b;  n_out_has = 1'b1;
                            n_out_last = 1'b0;  n_out_done = 1'b0;
                        end
                        n_pend_v = 1'b1;  n_pend_b = f_byte;
                    end
                    if (f_open) begin
                        n_in_ref = 1'b1;  n_cnt = '0;  n_num = '0;  n_nd = 1'b0;
                        n_key = '0;  n_sp = r_rp;
                    end
                    if (f_close || f_fail) begin
                        n_in_ref = 1'b0;  n_cnt = '0;  n_num = '0;  n_nd = 1'b0;
                    end
                    if (f_fail) n_rp = r_sp;
                    if (f_store) begin
                        if (numeric2 && r_cnt != '0) begin
                            if (!is_digit) n_nd = 1'b1;
                            else if (!r_nd) n_num = num_sat;
                        end
                        if (r_cnt == '0) n_hash = (rd_b == CH_HASH);
                        if (r_cnt < CW'(NAME_MAX)) n_key = {r_key[39:0], rd_b};
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_state = S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_wp <= '0;  r_rp <= '0;  r_sp <= '0;
            r_end <= 1'b0;  r_in_ref <= 1'b0;  r_cnt <= '0;  r_num <= '0;
            r_nd <= 1'b0;  r_hash <= 1'b0;  r_pend_v <= 1'b0;  r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;  r_wp <= n_wp;  r_rp <= n_rp;  r_sp <= n_sp;
            r_end <= n_end;  r_in_ref <= n_in_ref;  r_cnt <= n_cnt;  r_num <= n_num;
            r_nd <= n_nd;  r_hash <= n_hash;  r_pend_v <= n_pend_v;  r_out_v <= n_out_v;
        end
        r_key <= n_key;  r_pend_b <= n_pend_b;  r_out_b <= n_out_b;
        r_out_has <= n_out_has;  r_out_last <= n_out_last;  r_out_done <= n_out_done;
    end

    assign o_out.valid       = r_out_v;
    assign o_out.out_byte    = r_out_b;
    assign o_out.has_byte    = r_out_has;
    assign o_out.run_last    = r_out_last;
    assign o_out.string_done = r_out_done;

    `HED_ASSERT(a_cnt_closed, i_clk, i_rst_n, (!r_in_ref |-> r_cnt == '0))
    `HED_ASSERT(a_cnt_window, i_clk, i_rst_n, (r_cnt <= CW'(REF_WINDOW)))
    `HED_ASSERT(a_live_span, i_clk, i_rst_n, (r_in_ref |-> PW'(r_wp - r_sp) <= PW'(REF_WINDOW + 1)))
    `HED_ASSERT(a_idle_no_pend, i_clk, i_rst_n, (r_state == S_IDLE |-> !r_pend_v))
    `HED_ASSERT_NEXT(a_pop_reads, i_clk, i_rst_n, o_pop, r_state == S_RD)
endmodule

### rtl/html_entity_decoder.sv
// Timing: each byte scanned, fresh or replayed from the line buffer, passes
// through a read state and an execute state in the back end, which takes no
// new byte until every stored byte is scanned; the line buffer has a single
// read port, and a failed reference replays up to 33 bytes.
// Reset: synchronous, active low; clears all control state, no clearing pass.
// Top level of the HTML character reference decoder, Latin-1 names.
// Depends on hed_pkg, hed_ifs, hed_front, hed_back.
module html_entity_decoder import hed_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hed_in_if.sink    i_in,
    hed_out_if.source o_out
);
    // Front end holds up to two input words, taking them off the channel
    // while the back end is busy, for instance replaying a failed reference.
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    hed_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Back end: every byte lands in a circular line buffer; a failed
    // reference rewinds the read pointer to the byte after the ampersand.
    // The last emitted byte waits in a pending register so run_last can be set.
    hed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );
endmodule

### tb/html_entity_decoder_tb.sv
// Testbench for html_entity_decoder: drives text words, predicts decoded words.
// Depends on hed_pkg, hed_ifs and the decoder RTL.
module html_entity_decoder_tb;
    import hed_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN       = 32;
    localparam int NAME_LEN  = 6;
    localparam int N_RANDOM  = 120;
    localparam int IDLE_PCT  = 24;
    localparam int STALL_LIM = 20000;
    localparam logic [7:0] AMP  = 8'h26;
    localparam logic [7:0] SEMI = 8'h3B;
    localparam logic [7:0] HASH = 8'h23;

    // one decoded output word
    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       run_last;
        logic       done;
    } t_word;

    // directed row: text word plus, where obvious, the words it must give
    typedef struct {
        logic [7:0] data;
        logic       last;
        int         n_fixed;   // -1: use the predictor
        logic [7:0] fixed0;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    hed_in_if  in_ch();
    hed_out_if out_ch();

    html_entity_decoder u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    // ---- decoder shadow state ----
    logic [7:0] held [WIN];
    int         held_n;
    bit         open_ref;
    int         num_val;
    bit         bad_digit;
    logic [7:0] rescan [$];
    logic [7:0] decoded [$];

    t_word expected_words [$];
    bit    failed;
    int    quiet_cycles;
    bit    no_idle;

    function automatic void shut_ref();
        open_ref  = 0;
        held_n    = 0;
        num_val   = 0;
        bad_digit = 0;
    endfunction

    // bail out: ampersand goes out, held bytes (and extra) rescanned ahead of the rest
    function automatic void abandon_ref(bit with_extra, logic [7:0] extra);
        logic [7:0] tmp [$];
        decoded.push_back(AMP);
        for (int i = 0; i < held_n; i++) tmp.push_back(held[i]);
        if (with_extra) tmp.push_back(extra);
        foreach (rescan[i]) tmp.push_back(rescan[i]);
        rescan = tmp;
        shut_ref();
    endfunction

    function automatic bit code_ok(int v);
        return !(v <= 8 || (v >= 11 && v <= 31) || (v >= 127 && v <= 160) || v >= 256);
    endfunction

    function automatic int lookup_name();
        int len;
        bit hit;
        for (int k = 0; k < NAME_COUNT; k++) begin
            len = NAME_ROM[k].len;
            if (len == held_n) begin
                hit = 1;
                for (int i = 0; i < len; i++)
                    if (NAME_ROM[k].txt[8*(len-1-i) +: 8] != held[i]) hit = 0;
                if (hit) return NAME_ROM[k].code;
            end
        end
        return -1;
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        bit is_num;
        int code;
        if (!open_ref) begin
            if (b == AMP) begin
                shut_ref();
                open_ref = 1;
            end else decoded.push_back(b);
            return;
        end
        is_num = (held_n > 0 && held[0] == HASH);
        if (b == SEMI) begin
            if (is_num) begin
                if (!bad_digit && code_ok(num_val)) decoded.push_back(num_val[7:0]);
                shut_ref();
                return;
            end
            code = lookup_name();
            if (code >= 0) begin
                decoded.push_back(code[7:0]);
                shut_ref();
            end else abandon_ref(1, b);
            return;
        end
        if (held_n == 0 && b == HASH) is_num = 1;
        if (held_n >= WIN || (!is_num && held_n >= NAME_LEN)) begin
            abandon_ref(1, b);
            return;
        end
        if (is_num && held_n > 0) begin
            if (b >= 8'h30 && b <= 8'h39) begin
                if (!bad_digit) begin
                    num_val = num_val * 10 + (b - 8'h30);
                    if (num_val > 256) num_val = 256;
                end
            end else bad_digit = 1;
        end
        held[held_n] = b;
        held_n++;
    endfunction

    function automatic void drain_rescan();
        logic [7:0] b;
        while (rescan.size() > 0) begin
            b = rescan.pop_front();
            scan_byte(b);
        end
    endfunction

    // predict the words one text word gives, append to expected_words
    function automatic void predict_decode(logic [7:0] b, logic last);
        t_word w;
        decoded.delete();
        rescan.delete();
        rescan.push_back(b);
        drain_rescan();
        if (last) begin
            while (open_ref) begin
                abandon_ref(0, 8'h00);
                drain_rescan();
            end
        end
        if (decoded.size() == 0) begin
            if (last) begin
                w = '{8'h00, 1'b0, 1'b1, 1'b1};
                expected_words.push_back(w);
            end
            return;
        end
        foreach (decoded[k]) begin
            w.data     = decoded[k];
            w.has_byte = 1'b1;
            w.run_last = (k == decoded.size() - 1);
            w.done     = w.run_last && last;
            expected_words.push_back(w);
        end
    endfunction

    // ---- sender ----
    // valid stays up after acceptance; the next word, an idle cycle or
    // wait_drained takes it over
    task automatic send_word(logic [7:0] b, logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_end  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // accepted at this edge
    endtask

    task automatic send_text(string s, logic last_on_end);
        for (int i = 0; i < s.len(); i++) begin
            predict_decode(s[i], last_on_end && (i == s.len() - 1));
            send_word(s[i], last_on_end && (i == s.len() - 1));
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // ---- receiver and checker ----
    always @(posedge i_clk) begin
        t_word exp_w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %h has=%b last=%b done=%b", $realtime,
                             out_ch.out_byte, out_ch.has_byte, out_ch.run_last,
                             out_ch.string_done);
                    failed = 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.data !== out_ch.out_byte || exp_w.has_byte !== out_ch.has_byte
                        || exp_w.run_last !== out_ch.run_last
                        || exp_w.done !== out_ch.string_done) begin
                        $display("%0t: mismatch exp %h/%b/%b/%b got %h/%b/%b/%b", $realtime,
                                 exp_w.data, exp_w.has_byte, exp_w.run_last, exp_w.done,
                                 out_ch.out_byte, out_ch.has_byte, out_ch.run_last,
                                 out_ch.string_done);
                        failed = 1;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIM) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // random text: named and numeric references, malformed ones and plain bytes
    function automatic string rand_chunk();
        string s;
        int pick;
        int n;
        pick = $urandom_range(9);
        case (pick)
            0, 1: begin
                n = $urandom_range(NAME_COUNT - 1);
                s = "&";
                for (int i = NAME_ROM[n].len - 1; i >= 0; i--)
                    s = {s, string'(NAME_ROM[n].txt[8*i +: 8])};
                if ($urandom_range(4) == 0) s[1] = s[1] ^ 8'h20;  // case flip
                s = {s, ";"};
            end
            2, 3: s = $sformatf("&#%0d;", $urandom_range(300));
            4: begin
                s = "&#";
                n = $urandom_range(WIN + 2);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h30, 8'h39)))};
                if ($urandom_range(1)) s = {s, ";"};
            end
            5: begin
                s = "&";
                n = $urandom_range(8);
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h41, 8'h7A)))};
                if ($urandom_range(1)) s = {s, ";"};
            end
            default: begin
                n = $urandom_range(1, 4);
                s = "";
                for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
            end
        endcase
        return s;
    endfunction

    t_row dir_rows [$];
    t_word w;

    initial begin
        int sent;
        string chunk;
        logic last;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_end  = 1'b0;
        out_ch.ready  = 1'b0;
        failed        = 0;
        quiet_cycles  = 0;
        no_idle       = 0;
        shut_ref();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, zero byte, end marker alone, then references
        // lone ampersand at string end comes back as itself, closing the string
        dir_rows = '{
            '{8'h00, 1'b0, 1, 8'h00}, '{8'hFF, 1'b0, 1, 8'hFF},
            '{8'h41, 1'b1, 1, 8'h41}, '{AMP,   1'b1, 1, AMP}
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].n_fixed < 0) predict_decode(dir_rows[i].data, dir_rows[i].last);
            else begin
                for (int k = 0; k < dir_rows[i].n_fixed; k++) begin
                    w.data = (k == 0) ? dir_rows[i].fixed0 : 8'h00;
                    w.has_byte = 1'b1;
                    w.run_last = (k == dir_rows[i].n_fixed - 1);
                    w.done = w.run_last && dir_rows[i].last;
                    expected_words.push_back(w);
                end
                shut_ref();
            end
            send_word(dir_rows[i].data, dir_rows[i].last);
        end
        wait_drained();

        send_text("&lt;&yacute;&#9;&#8;&#255;&#256;", 0);
        send_text("&#12a;&#;&x;&bogusname;&Lt;&#", 1);
        wait_drained();

        // long overlong numeric reference, no idling on either side
        no_idle = 1;
        send_text("&#0000000000000000000000000000000000099;x", 1);
        no_idle = 0;
        wait_drained();   // sender holds off until every result is in

        sent = 0;
        while (sent < N_RANDOM) begin
            chunk = rand_chunk();
            no_idle = (sent > 30 && sent < 80);
            for (int i = 0; i < chunk.len(); i++) begin
                last = ($urandom_range(24) == 0);
                predict_decode(chunk[i], last);
                send_word(chunk[i], last);
                sent++;
            end
        end
        no_idle = 0;
        predict_decode(8'h2E, 1'b1);
        send_word(8'h2E, 1'b1);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (!failed && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
